>>> design/fdra_pkg.sv
package fdra_pkg;

  localparam int MAX_PAGES_DEF      = 4;
  localparam int FREE_PER_PAGE_DEF  = 16;
  localparam int STALL_PER_PAGE_DEF = 16;

  localparam logic [15:0] PAGE_SIZE_MAX = 16'd32768;

  localparam logic [1:0] K_ALLOC   = 2'd0;
  localparam logic [1:0] K_RELEASE = 2'd1;
  localparam logic [1:0] K_RETIRE  = 2'd2;
  localparam logic [1:0] K_CLEAR   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_PAGE   = 3'd1;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [2:0] ST_BAD_PAGE  = 3'd3;
  localparam logic [2:0] ST_STALL_FUL = 3'd4;
  localparam logic [2:0] ST_FREE_FUL  = 3'd5;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
  } fent_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] last;
    logic [63:0] tag;
  } sent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ALLOC_NEXT,
    S_ALLOC_CHK,
    S_MOVE,
    S_MOVE_WR,
    S_RET_NEXT,
    S_RET_CHK,
    S_RET_KEEP,
    S_INS_NEXT,
    S_INS_CHK,
    S_OUT
  } state_t;

endpackage

>>> design/fdra_ram.sv
module fdra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/deferred_free_range_allocator.sv
// Allocate scans the free ranges of each open page in turn and opens a new page if none
//   fits; an exact fit erases the range by shifting the later ranges down. Bad size,
//   release and clear finish without a walk. Retire walks the stall entries of each open
//   page and inserts each due one into that page's free list, shifting ranges up as needed.
// One item at a time; the next beat is taken the cycle after the result leaves.
// Reset (synchronous, rst_n low): no pages open, all counts zero, page_size 32768.
// Range stores keep stale contents across reset and clear; counts gate every read.
module deferred_free_range_allocator import fdra_pkg::*; #(
  parameter int MAX_PAGES      = MAX_PAGES_DEF,
  parameter int FREE_PER_PAGE  = FREE_PER_PAGE_DEF,
  parameter int STALL_PER_PAGE = STALL_PER_PAGE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_block_size,
  input  logic [1:0]  in_block_page,
  input  logic [14:0] in_block_offset,
  input  logic [63:0] in_fence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_page,
  output logic [14:0] out_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int FCW = $clog2(FREE_PER_PAGE + 1);
  localparam int SCW = $clog2(STALL_PER_PAGE + 1);
  localparam int FD  = MAX_PAGES * FREE_PER_PAGE;
  localparam int SD  = MAX_PAGES * STALL_PER_PAGE;
  localparam int FAW = (FD > 1) ? $clog2(FD) : 1;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

  // Flat store addresses: page base plus entry index.
  function automatic logic [FAW-1:0] f_addr(logic [PW-1:0] p, logic [FCW-1:0] k);
    int a;
    a = int'(p) * FREE_PER_PAGE + int'(k);
    return FAW'(a);
  endfunction

  function automatic logic [SAW-1:0] s_addr(logic [PW-1:0] p, logic [SCW-1:0] k);
    int a;
    a = int'(p) * STALL_PER_PAGE + int'(k);
    return SAW'(a);
  endfunction

  state_t state_r, state_nxt;

  // Captured input beat.
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] size_r, size_nxt;
  logic [1:0]  bpage_r, bpage_nxt;
  logic [14:0] boff_r, boff_nxt;
  logic [63:0] fence_r, fence_nxt;

  logic [15:0]    page_size_r;
  logic [PCW-1:0] pages_open_r, pages_open_nxt;
  logic [FCW-1:0] free_count_r [MAX_PAGES];
  logic [FCW-1:0] free_count_nxt [MAX_PAGES];
  logic [SCW-1:0] stall_count_r [MAX_PAGES];
  logic [SCW-1:0] stall_count_nxt [MAX_PAGES];

  // Sequencer walk registers.
  logic [PCW-1:0] p_r, p_nxt;
  logic [SCW-1:0] i_r, i_nxt;
  logic [SCW-1:0] keep_r, keep_nxt;
  logic [FCW-1:0] idx_r, idx_nxt;
  logic [FCW-1:0] j_r, j_nxt;
  logic           up_r, up_nxt;
  logic           sfail_r, sfail_nxt;
  fent_t          prev_r, prev_nxt;
  sent_t          st_r, st_nxt;

  // Result beat.
  logic [2:0]  status_r, status_nxt;
  logic [1:0]  opage_r, opage_nxt;
  logic [14:0] ooff_r, ooff_nxt;

  // Store ports.
  logic           fwe, swe;
  logic [FAW-1:0] fwaddr, fraddr;
  logic [SAW-1:0] swaddr, sraddr;
  fent_t          fwdata, frdata;
  sent_t          swdata, srdata;

  fdra_ram #(.WIDTH($bits(fent_t)), .DEPTH(FD)) u_free_ram (
    .clk   (clk),
    .we    (fwe),
    .waddr (fwaddr),
    .wdata (fwdata),
    .raddr (fraddr),
    .rdata (frdata)
  );

  fdra_ram #(.WIDTH($bits(sent_t)), .DEPTH(SD)) u_stall_ram (
    .clk   (clk),
    .we    (swe),
    .waddr (swaddr),
    .wdata (swdata),
    .raddr (sraddr),
    .rdata (srdata)
  );

  // Shared decision terms.
  logic [15:0]    ps;
  logic [PW-1:0]  pidx, pnew, bpidx;
  logic [FCW-1:0] fcnt;
  logic [SCW-1:0] scnt, bscnt;
  logic [16:0]    rel_end;
  logic           bad_alloc, p_end, idx_end, r_end, hit, hit_exact, mv_cont, due;
  logic           prev_join, n_full, e_before, e_touch, pages_full;
  logic [15:0]    fsum;

  assign ps = (page_size_r == 16'd0) ? 16'd1 :
              (page_size_r > PAGE_SIZE_MAX) ? PAGE_SIZE_MAX : page_size_r;

  assign pidx   = p_r[PW-1:0];
  assign pnew   = pages_open_r[PW-1:0];
  assign bpidx  = PW'(bpage_r);
  assign fcnt   = free_count_r[pidx];
  assign scnt   = stall_count_r[pidx];
  assign bscnt  = stall_count_r[bpidx];
  assign rel_end = {2'b00, boff_r} + {1'b0, size_r};

  assign bad_alloc  = (size_r == 16'd0) || (size_r > ps);
  assign p_end      = int'(p_r) >= int'(pages_open_r);
  assign pages_full = int'(pages_open_r) >= MAX_PAGES;
  assign idx_end    = idx_r >= fcnt;
  assign r_end      = i_r >= scnt;
  assign fsum       = frdata.first + size_r;
  assign hit        = (frdata.last >= frdata.first) &&
                      ((frdata.last - frdata.first) >= size_r);
  assign hit_exact  = fsum == frdata.last;
  assign mv_cont    = up_r ? (j_r > idx_r) : (int'(j_r) + 1 < int'(fcnt));
  assign due        = srdata.tag <= fence_r;
  assign prev_join  = prev_r.last == st_r.first;
  assign n_full     = int'(fcnt) >= FREE_PER_PAGE;
  assign e_before   = frdata.first < st_r.first;
  assign e_touch    = frdata.first == st_r.last;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        case (kind_r)
          K_ALLOC:  state_nxt = bad_alloc ? S_OUT : S_ALLOC_NEXT;
          K_RETIRE: state_nxt = S_RET_NEXT;
          default:  state_nxt = S_OUT;
        endcase
      end
      S_ALLOC_NEXT: begin
        if (p_end) state_nxt = S_OUT;
        else if (!idx_end) state_nxt = S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        if (hit) state_nxt = hit_exact ? S_MOVE : S_OUT;
        else state_nxt = S_ALLOC_NEXT;
      end
      S_MOVE: begin
        if (mv_cont) state_nxt = S_MOVE_WR;
        else if (!up_r && kind_r == K_ALLOC) state_nxt = S_OUT;
        else state_nxt = S_RET_NEXT;
      end
      S_MOVE_WR: state_nxt = S_MOVE;
      S_RET_NEXT: begin
        if (p_end) state_nxt = S_OUT;
        else if (!r_end) state_nxt = S_RET_CHK;
      end
      S_RET_CHK: state_nxt = due ? S_INS_NEXT : S_RET_KEEP;
      S_RET_KEEP: state_nxt = S_RET_NEXT;
      S_INS_NEXT: begin
        if (!idx_end) state_nxt = S_INS_CHK;
        else if (fcnt != '0 && prev_join) state_nxt = S_RET_NEXT;
        else if (n_full) state_nxt = S_RET_KEEP;
        else state_nxt = S_RET_NEXT;
      end
      S_INS_CHK: begin
        if (e_before) state_nxt = S_INS_NEXT;
        else if (!e_touch) begin
          if (idx_r != '0 && prev_join) state_nxt = S_RET_NEXT;
          else if (n_full) state_nxt = S_RET_KEEP;
          else state_nxt = S_MOVE;
        end else begin
          state_nxt = (idx_r != '0 && prev_join) ? S_MOVE : S_RET_NEXT;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store control.
  always_comb begin
    kind_nxt        = kind_r;
    size_nxt        = size_r;
    bpage_nxt       = bpage_r;
    boff_nxt        = boff_r;
    fence_nxt       = fence_r;
    pages_open_nxt  = pages_open_r;
    free_count_nxt  = free_count_r;
    stall_count_nxt = stall_count_r;
    p_nxt           = p_r;
    i_nxt           = i_r;
    keep_nxt        = keep_r;
    idx_nxt         = idx_r;
    j_nxt           = j_r;
    up_nxt          = up_r;
    sfail_nxt       = sfail_r;
    prev_nxt        = prev_r;
    st_nxt          = st_r;
    status_nxt      = status_r;
    opage_nxt       = opage_r;
    ooff_nxt        = ooff_r;
    fwe    = 1'b0;
    fwaddr = '0;
    fwdata = '0;
    fraddr = '0;
    swe    = 1'b0;
    swaddr = '0;
    swdata = '0;
    sraddr = '0;

    case (state_r)
      S_IDLE: begin
        // Hold the beat for the whole walk.
        if (in_valid) begin
          kind_nxt  = in_kind;
          size_nxt  = in_block_size;
          bpage_nxt = in_block_page;
          boff_nxt  = in_block_offset;
          fence_nxt = in_fence;
        end
      end
      S_START: begin
        status_nxt = ST_OK;
        opage_nxt  = '0;
        ooff_nxt   = '0;
        case (kind_r)
          K_ALLOC: begin
            if (bad_alloc) status_nxt = ST_BAD_SIZE;
            p_nxt   = '0;
            idx_nxt = '0;
          end
          K_RELEASE: begin
            if (size_r > ps) begin
              status_nxt = ST_OK;
            end else if (size_r == 16'd0 || rel_end > {1'b0, ps}) begin
              status_nxt = ST_BAD_SIZE;
            end else if (int'(bpage_r) >= int'(pages_open_r)) begin
              status_nxt = ST_BAD_PAGE;
            end else if (int'(bscnt) >= STALL_PER_PAGE) begin
              status_nxt = ST_STALL_FUL;
            end else begin
              swe    = 1'b1;
              swaddr = s_addr(bpidx, bscnt);
              swdata = '{first: {1'b0, boff_r}, last: rel_end[15:0], tag: fence_r};
              stall_count_nxt[bpidx] = bscnt + 1'b1;
            end
          end
          K_RETIRE: begin
            p_nxt     = '0;
            i_nxt     = '0;
            keep_nxt  = '0;
            sfail_nxt = 1'b0;
          end
          default: begin
            pages_open_nxt = '0;
            for (int k = 0; k < MAX_PAGES; k++) begin
              free_count_nxt[k]  = '0;
              stall_count_nxt[k] = '0;
            end
          end
        endcase
      end
      S_ALLOC_NEXT: begin
        if (p_end) begin
          // Nothing fits: open a fresh page if one is left.
          if (pages_full) begin
            status_nxt = ST_NO_PAGE;
          end else begin
            pages_open_nxt        = pages_open_r + 1'b1;
            stall_count_nxt[pnew] = '0;
            if (size_r < ps) begin
              fwe    = 1'b1;
              fwaddr = f_addr(pnew, '0);
              fwdata = '{first: size_r, last: ps};
              free_count_nxt[pnew] = FCW'(1);
            end else begin
              free_count_nxt[pnew] = '0;
            end
            opage_nxt = 2'(pages_open_r);
            ooff_nxt  = '0;
          end
        end else if (idx_end) begin
          p_nxt   = p_r + 1'b1;
          idx_nxt = '0;
        end else begin
          fraddr = f_addr(pidx, idx_r);
        end
      end
      S_ALLOC_CHK: begin
        if (hit) begin
          opage_nxt = 2'(p_r);
          ooff_nxt  = frdata.first[14:0];
          if (hit_exact) begin
            j_nxt  = idx_r;
            up_nxt = 1'b0;
          end else begin
            fwe    = 1'b1;
            fwaddr = f_addr(pidx, idx_r);
            fwdata = '{first: fsum, last: frdata.last};
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MOVE: begin
        if (mv_cont) begin
          fraddr = up_r ? f_addr(pidx, j_r - 1'b1) : f_addr(pidx, j_r + 1'b1);
        end else if (up_r) begin
          // Gap is open: drop the new range in.
          fwe    = 1'b1;
          fwaddr = f_addr(pidx, idx_r);
          fwdata = '{first: st_r.first, last: st_r.last};
          free_count_nxt[pidx] = fcnt + 1'b1;
          i_nxt = i_r + 1'b1;
        end else begin
          free_count_nxt[pidx] = fcnt - 1'b1;
          if (kind_r != K_ALLOC) i_nxt = i_r + 1'b1;
        end
      end
      S_MOVE_WR: begin
        fwe    = 1'b1;
        fwaddr = f_addr(pidx, j_r);
        fwdata = frdata;
        j_nxt  = up_r ? j_r - 1'b1 : j_r + 1'b1;
      end
      S_RET_NEXT: begin
        if (p_end) begin
          status_nxt = sfail_r ? ST_FREE_FUL : ST_OK;
        end else if (r_end) begin
          stall_count_nxt[pidx] = keep_r;
          p_nxt    = p_r + 1'b1;
          i_nxt    = '0;
          keep_nxt = '0;
        end else begin
          sraddr = s_addr(pidx, i_r);
        end
      end
      S_RET_CHK: begin
        st_nxt  = srdata;
        idx_nxt = '0;
      end
      S_RET_KEEP: begin
        // Compact the survivor toward the front.
        swe      = 1'b1;
        swaddr   = s_addr(pidx, keep_r);
        swdata   = st_r;
        keep_nxt = keep_r + 1'b1;
        i_nxt    = i_r + 1'b1;
      end
      S_INS_NEXT: begin
        if (!idx_end) begin
          fraddr = f_addr(pidx, idx_r);
        end else if (fcnt != '0 && prev_join) begin
          fwe    = 1'b1;
          fwaddr = f_addr(pidx, fcnt - 1'b1);
          fwdata = '{first: prev_r.first, last: st_r.last};
          i_nxt  = i_r + 1'b1;
        end else if (n_full) begin
          sfail_nxt = 1'b1;
        end else begin
          fwe    = 1'b1;
          fwaddr = f_addr(pidx, fcnt);
          fwdata = '{first: st_r.first, last: st_r.last};
          free_count_nxt[pidx] = fcnt + 1'b1;
          i_nxt  = i_r + 1'b1;
        end
      end
      S_INS_CHK: begin
        if (e_before) begin
          prev_nxt = frdata;
          idx_nxt  = idx_r + 1'b1;
        end else if (!e_touch) begin
          if (idx_r != '0 && prev_join) begin
            fwe    = 1'b1;
            fwaddr = f_addr(pidx, idx_r - 1'b1);
            fwdata = '{first: prev_r.first, last: st_r.last};
            i_nxt  = i_r + 1'b1;
          end else if (n_full) begin
            sfail_nxt = 1'b1;
          end else begin
            up_nxt = 1'b1;
            j_nxt  = fcnt;
          end
        end else if (idx_r != '0 && prev_join) begin
          // Range bridges both neighbors: merge and erase the upper one.
          fwe    = 1'b1;
          fwaddr = f_addr(pidx, idx_r - 1'b1);
          fwdata = '{first: prev_r.first, last: frdata.last};
          up_nxt = 1'b0;
          j_nxt  = idx_r;
        end else begin
          fwe    = 1'b1;
          fwaddr = f_addr(pidx, idx_r);
          fwdata = '{first: st_r.first, last: frdata.last};
          i_nxt  = i_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_size_r  <= PAGE_SIZE_MAX;
      pages_open_r <= '0;
      for (int k = 0; k < MAX_PAGES; k++) begin
        free_count_r[k]  <= '0;
        stall_count_r[k] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      pages_open_r  <= pages_open_nxt;
      free_count_r  <= free_count_nxt;
      stall_count_r <= stall_count_nxt;
      if (cfg_valid) page_size_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    size_r   <= size_nxt;
    bpage_r  <= bpage_nxt;
    boff_r   <= boff_nxt;
    fence_r  <= fence_nxt;
    p_r      <= p_nxt;
    i_r      <= i_nxt;
    keep_r   <= keep_nxt;
    idx_r    <= idx_nxt;
    j_r      <= j_nxt;
    up_r     <= up_nxt;
    sfail_r  <= sfail_nxt;
    prev_r   <= prev_nxt;
    st_r     <= st_nxt;
    status_r <= status_nxt;
    opage_r  <= opage_nxt;
    ooff_r   <= ooff_nxt;
  end

  assign in_stall   = state_r != S_IDLE;
  assign out_valid  = state_r == S_OUT;
  assign out_status = status_r;
  assign out_page   = opage_r;
  assign out_offset = ooff_r;
  assign cfg_ready  = 1'b1;

endmodule
